// File: hdl/xrg_pkg.sv
// Package: shared types and constants for the xoshiro256** generator.
`timescale 1ns / 1ps
package xrg_pkg;
    localparam logic [63:0] GOLDEN_STEP   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A     = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B     = 64'h94D049BB133111EB;
    localparam logic [63:0] SEED_AT_RESET = 64'hDEADBEEFCAFEBABE;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_RESEED  = 2'd0,
        OP_RAW     = 2'd1,
        OP_BOUNDED = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CMD_ZERO    = 2'd0,
        CMD_RESEED  = 2'd1,
        CMD_RAW     = 2'd2,
        CMD_BOUNDED = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [63:0] span;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX_ADD,
        ST_MIX_MA,
        ST_MIX_MA1,
        ST_MIX_MA2,
        ST_MIX_MB,
        ST_MIX_MB1,
        ST_MIX_MB2,
        ST_MIX_FIN,
        ST_LIM_DIV,
        ST_DRAW_MUL,
        ST_DRAW_FIN,
        ST_MOD_DIV,
        ST_DONE
    } t_state;

    function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] k);
        logic [127:0] w;
        begin
            w = {v, v} << k;
            rotl = w[127:64];
        end
    endfunction
endpackage

// File: hdl/xoshiro_random_generator.sv
// Top level: xoshiro256** generator with seed register, command queue and back end.
// A reseed expands the seed into the four state words; a bounded draw runs two serial
// remainder passes and draws again after each rejected draw.
// Throughput: one command at a time in the back end; a two-entry queue buffers input.
// Reset (synchronous, active low) loads seed 0xDEADBEEFCAFEBABE and expands it into
// the state; no command is started during the expansion.
`timescale 1ns / 1ps
module xoshiro_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_range_max,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_value,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata
);
    logic [63:0]   r_seed;
    logic          w_cmd_valid, w_cmd_ready;
    xrg_pkg::t_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= xrg_pkg::SEED_AT_RESET;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    xrg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_range_max (i_range_max),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    xrg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed      (r_seed),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value)
    );
endmodule

// File: hdl/xrg_front.sv
// Front end: accept and classify commands into a short queue.
`timescale 1ns / 1ps
module xrg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_opcode,
    input  logic [63:0]       i_range_max,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output xrg_pkg::t_cmd     o_cmd
);
    xrg_pkg::t_cmd r_q [xrg_pkg::QUEUE_DEPTH];
    logic          r_wp, n_wp, r_rp, n_rp;
    logic [1:0]    r_cnt, n_cnt;
    xrg_pkg::t_cmd w_cls;
    logic          w_push, w_pop;

    always_comb begin
        w_cls.span = i_range_max + 64'd1;
        case (xrg_pkg::t_opcode'(i_opcode))
            xrg_pkg::OP_RESEED: w_cls.kind = xrg_pkg::CMD_RESEED;
            xrg_pkg::OP_RAW:    w_cls.kind = xrg_pkg::CMD_RAW;
            xrg_pkg::OP_BOUNDED: begin
                if (i_range_max == 64'd0) begin
                    w_cls.kind = xrg_pkg::CMD_ZERO;
                end else if (i_range_max == '1) begin
                    w_cls.kind = xrg_pkg::CMD_RAW;
                end else begin
                    w_cls.kind = xrg_pkg::CMD_BOUNDED;
                end
            end
            default: w_cls.kind = xrg_pkg::CMD_ZERO;
        endcase
    end

    assign o_ready     = (r_cnt != 2'(xrg_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign n_wp        = w_push ? ~r_wp : r_wp;
    assign n_rp        = w_pop ? ~r_rp : r_rp;
    assign n_cnt       = r_cnt + 2'(w_push) - 2'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(xrg_pkg::QUEUE_DEPTH)) else $error("queue overflow");
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt == $past(r_cnt) + 2'd1) else $error("push lost");
    a_pop_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> r_cnt == $past(r_cnt) - 2'd1) else $error("pop lost");
endmodule

// File: hdl/xrg_divider.sv
// Serial 64-bit restoring divider giving the remainder, one bit per cycle.
`timescale 1ns / 1ps
module xrg_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_rem
);
    logic [63:0] r_rem, r_quo, r_div;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] w_sh, w_sub;

    assign w_sh   = {r_rem, r_quo[63]};
    assign w_sub  = w_sh - {1'b0, r_div};
    assign o_done = r_done;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rem <= 64'd0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[62:0], 1'b0};
            r_rem <= w_sub[64] ? w_sh[63:0] : w_sub[63:0];
        end
    end

    a_done_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && r_cnt == 7'd64) else $error("start missed");
    a_rem_lt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_rem < r_div) else $error("remainder too large");
endmodule

// File: hdl/xrg_back.sv
// Back end: state words, splitmix seeding, draws and bounded reduction.
`timescale 1ns / 1ps
module xrg_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [63:0]       i_seed,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  xrg_pkg::t_cmd     i_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [63:0]       o_value
);
    xrg_pkg::t_state r_st, n_st;
    logic [63:0] r_w [4];
    logic [63:0] r_ctr, r_z, r_span, r_lim, r_raw, r_out, r_mul, r_p;
    logic [1:0]  r_idx;
    logic        r_boot, r_ov;
    xrg_pkg::t_cmd_kind r_kind;
    logic        w_div_start, w_div_done;
    logic [63:0] w_div_a, w_div_b, w_rem, w_z1, w_za, w_raw;
    logic [63:0] w_mx, w_mc, w_prod;
    logic [31:0] w_ma, w_mb;
    logic        w_take, w_drain, w_use_a;

    assign w_drain     = !r_ov || i_ready;
    assign o_cmd_ready = (r_st == xrg_pkg::ST_IDLE) && !r_boot;
    assign w_take      = i_cmd_valid && o_cmd_ready;
    assign o_valid     = r_ov;
    assign o_value     = r_out;
    assign w_z1        = r_z ^ (r_z >> 27);
    assign w_za        = r_z ^ (r_z >> 30);
    assign w_raw       = (r_mul << 3) + r_mul;
    assign w_use_a     = (r_st == xrg_pkg::ST_MIX_MA) || (r_st == xrg_pkg::ST_MIX_MA1)
                         || (r_st == xrg_pkg::ST_MIX_MA2);
    assign w_mx        = w_use_a ? w_za : w_z1;
    assign w_mc        = w_use_a ? xrg_pkg::MIX_MUL_A : xrg_pkg::MIX_MUL_B;
    assign w_prod      = 64'(w_ma) * 64'(w_mb);

    xrg_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        case (r_st)
            xrg_pkg::ST_MIX_MA1, xrg_pkg::ST_MIX_MB1: begin
                w_ma = w_mx[31:0];
                w_mb = w_mc[63:32];
            end
            xrg_pkg::ST_MIX_MA2, xrg_pkg::ST_MIX_MB2: begin
                w_ma = w_mx[63:32];
                w_mb = w_mc[31:0];
            end
            default: begin
                w_ma = w_mx[31:0];
                w_mb = w_mc[31:0];
            end
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            xrg_pkg::ST_IDLE: begin
                if (r_boot) begin
                    n_st = xrg_pkg::ST_MIX_ADD;
                end else if (w_take) begin
                    case (i_cmd.kind)
                        xrg_pkg::CMD_RESEED:  n_st = xrg_pkg::ST_MIX_ADD;
                        xrg_pkg::CMD_RAW:     n_st = xrg_pkg::ST_DRAW_MUL;
                        xrg_pkg::CMD_BOUNDED: n_st = xrg_pkg::ST_LIM_DIV;
                        default:              n_st = xrg_pkg::ST_DONE;
                    endcase
                end
            end
            xrg_pkg::ST_MIX_ADD: n_st = xrg_pkg::ST_MIX_MA;
            xrg_pkg::ST_MIX_MA:  n_st = xrg_pkg::ST_MIX_MA1;
            xrg_pkg::ST_MIX_MA1: n_st = xrg_pkg::ST_MIX_MA2;
            xrg_pkg::ST_MIX_MA2: n_st = xrg_pkg::ST_MIX_MB;
            xrg_pkg::ST_MIX_MB:  n_st = xrg_pkg::ST_MIX_MB1;
            xrg_pkg::ST_MIX_MB1: n_st = xrg_pkg::ST_MIX_MB2;
            xrg_pkg::ST_MIX_MB2: n_st = xrg_pkg::ST_MIX_FIN;
            xrg_pkg::ST_MIX_FIN:
                n_st = (r_idx == 2'd3) ? (r_boot ? xrg_pkg::ST_IDLE : xrg_pkg::ST_DONE)
                                       : xrg_pkg::ST_MIX_ADD;
            xrg_pkg::ST_LIM_DIV: if (w_div_done) n_st = xrg_pkg::ST_DRAW_MUL;
            xrg_pkg::ST_DRAW_MUL: n_st = xrg_pkg::ST_DRAW_FIN;
            xrg_pkg::ST_DRAW_FIN:
                if (r_kind != xrg_pkg::CMD_BOUNDED) begin
                    n_st = xrg_pkg::ST_DONE;
                end else if (w_raw >= r_lim) begin
                    n_st = xrg_pkg::ST_MOD_DIV;
                end else begin
                    n_st = xrg_pkg::ST_DRAW_MUL;
                end
            xrg_pkg::ST_MOD_DIV: if (w_div_done) n_st = xrg_pkg::ST_DONE;
            xrg_pkg::ST_DONE:    if (w_drain) n_st = xrg_pkg::ST_IDLE;
            default:             n_st = xrg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_div_start = 1'b0;
        w_div_a     = r_raw;
        w_div_b     = r_span;
        if (w_take && i_cmd.kind == xrg_pkg::CMD_BOUNDED) begin
            w_div_start = 1'b1;
            w_div_a     = 64'd0 - i_cmd.span;
            w_div_b     = i_cmd.span;
        end else if (r_st == xrg_pkg::ST_DRAW_FIN && r_kind == xrg_pkg::CMD_BOUNDED
                     && w_raw >= r_lim) begin
            w_div_start = 1'b1;
            w_div_a     = w_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= xrg_pkg::ST_IDLE;
            r_boot <= 1'b1;
            r_ov   <= 1'b0;
            r_idx  <= 2'd0;
            r_ctr  <= xrg_pkg::SEED_AT_RESET;
        end else begin
            r_st <= n_st;
            r_ov <= ((r_st == xrg_pkg::ST_DONE) && w_drain) || (r_ov && !i_ready);
            if (w_take) begin
                r_kind <= i_cmd.kind;
                r_span <= i_cmd.span;
                r_idx  <= 2'd0;
                r_ctr  <= i_seed;
            end
            case (r_st)
                xrg_pkg::ST_MIX_ADD: begin
                    r_ctr <= r_ctr + xrg_pkg::GOLDEN_STEP;
                    r_z   <= r_ctr + xrg_pkg::GOLDEN_STEP;
                end
                xrg_pkg::ST_MIX_MA, xrg_pkg::ST_MIX_MB: r_p <= w_prod;
                xrg_pkg::ST_MIX_MA1, xrg_pkg::ST_MIX_MB1:
                    r_p[63:32] <= r_p[63:32] + w_prod[31:0];
                xrg_pkg::ST_MIX_MA2, xrg_pkg::ST_MIX_MB2:
                    r_z <= {r_p[63:32] + w_prod[31:0], r_p[31:0]};
                xrg_pkg::ST_MIX_FIN: begin
                    r_w[r_idx] <= r_z ^ (r_z >> 31);
                    r_idx      <= r_idx + 2'd1;
                    if (r_idx == 2'd3) r_boot <= 1'b0;
                end
                xrg_pkg::ST_LIM_DIV: if (w_div_done) r_lim <= w_rem;
                xrg_pkg::ST_DRAW_MUL: begin
                    r_mul  <= xrg_pkg::rotl((r_w[1] << 2) + r_w[1], 6'd7);
                    r_w[2] <= r_w[2] ^ r_w[0];
                    r_w[3] <= r_w[3] ^ r_w[1];
                    r_w[1] <= r_w[1] ^ r_w[2] ^ r_w[0];
                    r_w[0] <= r_w[0] ^ r_w[3] ^ r_w[1];
                    r_z    <= r_w[1] << 17;
                end
                xrg_pkg::ST_DRAW_FIN: begin
                    r_raw  <= w_raw;
                    r_w[2] <= r_w[2] ^ r_z;
                    r_w[3] <= xrg_pkg::rotl(r_w[3], 6'd45);
                end
                xrg_pkg::ST_MOD_DIV: if (w_div_done) r_raw <= w_rem;
                xrg_pkg::ST_DONE: begin
                    if (w_drain) begin
                        r_out <= (r_kind == xrg_pkg::CMD_RAW || r_kind == xrg_pkg::CMD_BOUNDED)
                                 ? r_raw : 64'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    a_one_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> r_ov && $stable(r_out)) else $error("result dropped");
    a_no_take_boot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_boot |-> !o_cmd_ready) else $error("command taken during seeding");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> r_st == xrg_pkg::ST_IDLE) else $error("command taken while busy");
endmodule

// File: tb/sv/tb_xoshiro_random_generator.sv
// Testbench: checks the xoshiro256** generator's draws and reseeds against a local predictor.
`timescale 1ns / 1ps
module tb_xoshiro_random_generator;

    typedef struct {
        xrg_pkg::t_opcode op;
        logic [63:0]      top;
    } t_cmd_item;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  in_op = 2'd0;
    logic [63:0] in_top = 64'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] out_value;
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_wdata = 64'd0;

    t_cmd_item   pending_cmds[$];
    logic [63:0] expected_values[$];
    logic [63:0] seed_reg;
    logic [63:0] words[4];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          send_hold = 1'b0;
    int          errors = 0;
    longint      cycles = 0;

    xoshiro_random_generator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_opcode    (in_op),
        .i_range_max (in_top),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_value     (out_value),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] rot64(input logic [63:0] v, input int k);
        return (v << k) | (v >> (64 - k));
    endfunction

    function automatic void expand_words();
        logic [63:0] ctr;
        logic [63:0] z;
        ctr = seed_reg;
        for (int i = 0; i < 4; i++) begin
            ctr = ctr + 64'h9E3779B97F4A7C15;
            z = ctr;
            z = (z ^ (z >> 30)) * 64'hBF58476D1CE4E5B9;
            z = (z ^ (z >> 27)) * 64'h94D049BB133111EB;
            words[i] = z ^ (z >> 31);
        end
    endfunction

    function automatic logic [63:0] next_raw();
        logic [63:0] res;
        logic [63:0] t;
        res = rot64(words[1] * 64'd5, 7) * 64'd9;
        t = words[1] << 17;
        words[2] ^= words[0];
        words[3] ^= words[1];
        words[1] ^= words[2];
        words[0] ^= words[3];
        words[2] ^= t;
        words[3] = rot64(words[3], 45);
        return res;
    endfunction

    function automatic logic [63:0] predict_value(input t_cmd_item c);
        logic [63:0] span;
        logic [63:0] lim;
        logic [63:0] r;
        case (c.op)
            xrg_pkg::OP_RESEED: begin
                expand_words();
                return 64'd0;
            end
            xrg_pkg::OP_RAW: return next_raw();
            xrg_pkg::OP_BOUNDED: begin
                if (c.top == 64'd0) return 64'd0;
                if (c.top == '1) return next_raw();
                span = c.top + 64'd1;
                lim = (64'd0 - span) % span;
                do r = next_raw(); while (r < lim);
                return r % span;
            end
            default: return 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: v = v >> $urandom_range(0, 63);
            1: v = v | (64'd1 << $urandom_range(0, 63));
            default: ;
        endcase
        return v;
    endfunction

    function automatic void add_cmd(input xrg_pkg::t_opcode op, input logic [63:0] top);
        t_cmd_item c;
        c.op = op;
        c.top = top;
        pending_cmds.push_back(c);
    endfunction

    always @(posedge clk) begin
        if (in_valid && in_ready) begin
            t_cmd_item c;
            c.op = xrg_pkg::t_opcode'(in_op);
            c.top = in_top;
            expected_values.push_back(predict_value(c));
        end
        if (rst_n && (!in_valid || in_ready)) begin
            if (pending_cmds.size() > 0 && !send_hold
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_op <= pending_cmds[0].op;
                in_top <= pending_cmds[0].top;
                void'(pending_cmds.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            if (expected_values.size() == 0) begin
                $display("%0t: unexpected transfer, value %h", $time, out_value);
                errors++;
            end else begin
                if (out_value !== expected_values[0]) begin
                    $display("%0t: value mismatch, expected %h actual %h",
                             $time, expected_values[0], out_value);
                    errors++;
                end
                void'(expected_values.pop_front());
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > 2000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic drain();
        wait (pending_cmds.size() == 0 && !in_valid && expected_values.size() == 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        seed_reg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n, input int s_pct, input int r_pct);
        int k;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 5) add_cmd(xrg_pkg::OP_RESEED, rand64());
            else if (k < 40) add_cmd(xrg_pkg::OP_RAW, rand64());
            else if (k < 45) add_cmd(xrg_pkg::OP_NONE, rand64());
            else if (k < 50) add_cmd(xrg_pkg::OP_BOUNDED, $urandom_range(0, 1) ? 64'd0 : '1);
            else if (k < 60) add_cmd(xrg_pkg::OP_BOUNDED,
                                     (64'd1 << 63) + rand64() % (64'd1 << 63));
            else add_cmd(xrg_pkg::OP_BOUNDED, rand64());
        end
    endtask

    initial begin
        seed_reg = xrg_pkg::SEED_AT_RESET;
        expand_words();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        add_cmd(xrg_pkg::OP_RAW, 64'd0);
        add_cmd(xrg_pkg::OP_RAW, '1);
        add_cmd(xrg_pkg::OP_BOUNDED, 64'd0);
        add_cmd(xrg_pkg::OP_BOUNDED, '1);
        add_cmd(xrg_pkg::OP_BOUNDED, 64'd1);
        add_cmd(xrg_pkg::OP_BOUNDED, 64'd6);
        add_cmd(xrg_pkg::OP_BOUNDED, 64'h8000_0000_0000_0000);
        add_cmd(xrg_pkg::OP_BOUNDED, 64'hFFFF_FFFF_FFFF_FFFE);
        add_cmd(xrg_pkg::OP_BOUNDED, 64'h5555_5555_5555_5555);
        add_cmd(xrg_pkg::OP_BOUNDED, 64'hAAAA_AAAA_AAAA_AAAA);
        add_cmd(xrg_pkg::OP_NONE, '1);
        add_cmd(xrg_pkg::OP_RESEED, 64'd0);
        add_cmd(xrg_pkg::OP_RAW, 64'd0);
        drain();

        write_seed(64'd0);
        add_cmd(xrg_pkg::OP_RESEED, 64'd0);
        add_cmd(xrg_pkg::OP_RAW, 64'd0);
        random_phase(300, 15, 81);
        drain();

        write_seed('1);
        add_cmd(xrg_pkg::OP_RESEED, 64'd0);
        random_phase(300, 81, 15);
        drain();

        write_seed({$urandom, $urandom});
        send_hold = 1'b1;
        add_cmd(xrg_pkg::OP_RESEED, 64'd0);
        random_phase(1300, 0, 0);
        send_hold = 1'b0;
        repeat (300) begin
            @(posedge clk);
            if ($urandom_range(0, 99) < 3) begin
                send_hold = 1'b1;
                wait (!in_valid && expected_values.size() == 0);
                @(posedge clk);
                send_hold = 1'b0;
            end
        end
        drain();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// File: filelist.f
hdl/xrg_pkg.sv
hdl/xrg_front.sv
hdl/xrg_divider.sv
hdl/xrg_back.sv
hdl/xoshiro_random_generator.sv
tb/sv/tb_xoshiro_random_generator.sv
